[hw/rtl/assert_macros.svh]
// Assertion helpers for the RTL; used by depthwise_2d_convolution.sv.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DW2D_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define DW2D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/dw2d_pkg.sv]
package dw2d_pkg;

  localparam int KIND_W    = 2;
  localparam int VALUE_W   = 8;
  localparam int PIX_OUT_W = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_WEIGHT = 2'd1,
    KIND_FETCH  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_ISSUE = 2'd1,
    ST_DRAIN = 2'd2,
    ST_OUT   = 2'd3
  } state_t;

  // Control that travels with one tap into the multiply-accumulate stage.
  typedef struct packed {
    logic tap;
    logic in_range;
    logic clear;
  } mac_ctl_t;

endpackage

[hw/rtl/dw2d_mac.sv]
module dw2d_mac #(
  parameter int PIXEL_WIDTH = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [PIXEL_WIDTH-1:0] pix,
  input  logic [PIXEL_WIDTH-1:0] wt,
  input  dw2d_pkg::mac_ctl_t     ctl,
  output logic [PIXEL_WIDTH-1:0] acc,
  output logic                   busy
);

  logic [2*PIXEL_WIDTH-1:0] full_prod;
  logic [PIXEL_WIDTH-1:0]   prod_r;
  logic [PIXEL_WIDTH-1:0]   prod_nxt;
  logic                     p2_r;
  logic [PIXEL_WIDTH-1:0]   acc_r;

  assign full_prod = pix * wt;
  // Zero padding: a tap outside the image adds nothing.
  assign prod_nxt  = ctl.in_range ? full_prod[PIXEL_WIDTH-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_r <= 1'b0;
    end else begin
      p2_r <= ctl.tap;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (p2_r) begin
      acc_r <= acc_r + prod_r;
    end
  end

  assign acc  = acc_r;
  assign busy = p2_r;

endmodule

[hw/rtl/depthwise_2d_convolution.sv]
// Channel   Dir  Data (tdata)          Side band
// in_       in   [7:0] value           tuser [1:0] kind
// out_      out  [7:0] pixel_out       tlast last
//
// A load (pixel or weight) writes one store entry; a fetch keeps in_tready low
// while it issues one tap per cycle through the single read port of each store,
// drains the multiply-accumulate pipeline and loads the output register. Loads
// and a fetch start while a result waits, but a finished fetch holds in_tready low
// until the output register is free.
// Reset clears the load and position counters and handshake state; the stores keep their contents.
`include "assert_macros.svh"

module depthwise_2d_convolution #(
  parameter int IMAGE_SIDE  = 32,
  parameter int KERNEL_SIDE = 3,
  parameter int CHANNELS    = 3,
  parameter int PIXEL_WIDTH = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [dw2d_pkg::VALUE_W-1:0]       in_tdata,   // [7:0] value
  input  logic [dw2d_pkg::KIND_W-1:0]        in_tuser,   // [1:0] kind
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [dw2d_pkg::PIX_OUT_W-1:0]     out_tdata,  // [7:0] pixel_out
  output logic                               out_tlast
);

  localparam int IMG_COUNT = IMAGE_SIDE * IMAGE_SIDE * CHANNELS;
  localparam int KER_COUNT = KERNEL_SIDE * KERNEL_SIDE * CHANNELS;
  localparam int HALF      = KERNEL_SIDE / 2;
  localparam int AW        = (IMG_COUNT > 1) ? $clog2(IMG_COUNT) : 1;
  localparam int WAW       = (KER_COUNT > 1) ? $clog2(KER_COUNT) : 1;
  localparam int RW        = $clog2(IMAGE_SIDE);
  localparam int CW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int KW        = (KERNEL_SIDE > 1) ? $clog2(KERNEL_SIDE) : 1;
  localparam int IW        = $clog2(IMAGE_SIDE + KERNEL_SIDE) + 2;
  localparam int ROW_STEP  = IMAGE_SIDE * CHANNELS;
  localparam int PIX_SPAN  = IMG_COUNT + KERNEL_SIDE * (IMAGE_SIDE + 1) * CHANNELS;
  localparam int PIW       = $clog2(PIX_SPAN) + 2;
  localparam int START_OFS = HALF * ROW_STEP + HALF * CHANNELS;
  localparam int ROW_JUMP  = ROW_STEP - (KERNEL_SIDE - 1) * CHANNELS;
  localparam int WIW       = $clog2(KER_COUNT + CHANNELS + 1);

  dw2d_pkg::state_t state_r, state_nxt;
  dw2d_pkg::kind_t  in_kind;

  logic [PIXEL_WIDTH-1:0] img_mem [IMG_COUNT];
  logic [PIXEL_WIDTH-1:0] wt_mem  [KER_COUNT];
  logic [PIXEL_WIDTH-1:0] img_rd_r, wt_rd_r, wdata;

  logic [AW-1:0]         pix_ld_r, pix_ld_nxt;
  logic [WAW-1:0]        wt_ld_r, wt_ld_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic [RW-1:0]         row_r, row_nxt, col_r, col_nxt;
  logic [CW-1:0]         ch_r, ch_nxt;
  logic [KW-1:0]         kr_r, kr_nxt, kc_r, kc_nxt;
  logic signed [IW-1:0]  ir_r, ir_nxt, ic_r, ic_nxt;
  logic signed [PIW-1:0] pi_r, pi_nxt;
  logic [WIW-1:0]        wi_r, wi_nxt;
  logic                  p1_r, inr1_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [dw2d_pkg::PIX_OUT_W-1:0] out_data_r, out_data_nxt;
  logic                  out_last_r, out_last_nxt;

  logic in_acc, img_we, wt_we, fetch_start, last_pos, last_tap, in_range;
  logic in_issue;
  logic [PIXEL_WIDTH-1:0] mac_acc;
  logic                   mac_busy;
  dw2d_pkg::mac_ctl_t     mac_ctl;

  assign in_tready = (state_r == dw2d_pkg::ST_IDLE);
  assign in_issue  = (state_r == dw2d_pkg::ST_ISSUE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_kind   = dw2d_pkg::kind_t'(in_tuser);
  assign wdata     = PIXEL_WIDTH'(in_tdata);
  assign img_we    = in_acc && (in_kind == dw2d_pkg::KIND_PIXEL);
  assign wt_we     = in_acc && (in_kind == dw2d_pkg::KIND_WEIGHT);
  assign fetch_start = in_acc && (in_kind == dw2d_pkg::KIND_FETCH);

  assign last_pos = (row_r == RW'(IMAGE_SIDE - 1)) && (col_r == RW'(IMAGE_SIDE - 1))
                    && (ch_r == CW'(CHANNELS - 1));
  assign last_tap = (kr_r == KW'(KERNEL_SIDE - 1)) && (kc_r == KW'(KERNEL_SIDE - 1));
  assign in_range = !ir_r[IW-1] && (ir_r < IW'(IMAGE_SIDE))
                    && !ic_r[IW-1] && (ic_r < IW'(IMAGE_SIDE));

  always_ff @(posedge clk) begin
    if (img_we) begin
      img_mem[pix_ld_r] <= wdata;
    end
    img_rd_r <= img_mem[pi_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wt_we) begin
      wt_mem[wt_ld_r] <= wdata;
    end
    wt_rd_r <= wt_mem[wi_r[WAW-1:0]];
  end

  always_comb begin
    state_nxt     = state_r;
    pix_ld_nxt    = pix_ld_r;
    wt_ld_nxt     = wt_ld_r;
    pos_nxt       = pos_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    ch_nxt        = ch_r;
    kr_nxt        = kr_r;
    kc_nxt        = kc_r;
    ir_nxt        = ir_r;
    ic_nxt        = ic_r;
    pi_nxt        = pi_r;
    wi_nxt        = wi_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      dw2d_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_kind)
            dw2d_pkg::KIND_PIXEL: begin
              pix_ld_nxt = (pix_ld_r == AW'(IMG_COUNT - 1)) ? '0 : pix_ld_r + 1'b1;
            end
            dw2d_pkg::KIND_WEIGHT: begin
              wt_ld_nxt = (wt_ld_r == WAW'(KER_COUNT - 1)) ? '0 : wt_ld_r + 1'b1;
            end
            dw2d_pkg::KIND_FETCH: begin
              // Start at the top-left tap of the window.
              kr_nxt    = '0;
              kc_nxt    = '0;
              ir_nxt    = $signed(IW'(row_r)) - $signed(IW'(HALF));
              ic_nxt    = $signed(IW'(col_r)) - $signed(IW'(HALF));
              pi_nxt    = $signed(PIW'(pos_r)) - $signed(PIW'(START_OFS));
              wi_nxt    = WIW'(ch_r);
              state_nxt = dw2d_pkg::ST_ISSUE;
            end
            default: begin
            end
          endcase
        end
      end
      dw2d_pkg::ST_ISSUE: begin
        wi_nxt = wi_r + WIW'(CHANNELS);
        if (kc_r == KW'(KERNEL_SIDE - 1)) begin
          kc_nxt = '0;
          kr_nxt = kr_r + 1'b1;
          ir_nxt = ir_r + 1'b1;
          ic_nxt = $signed(IW'(col_r)) - $signed(IW'(HALF));
          pi_nxt = pi_r + $signed(PIW'(ROW_JUMP));
        end else begin
          kc_nxt = kc_r + 1'b1;
          ic_nxt = ic_r + 1'b1;
          pi_nxt = pi_r + $signed(PIW'(CHANNELS));
        end
        if (last_tap) begin
          state_nxt = dw2d_pkg::ST_DRAIN;
        end
      end
      dw2d_pkg::ST_DRAIN: begin
        if (!p1_r && !mac_busy) begin
          state_nxt = dw2d_pkg::ST_OUT;
        end
      end
      dw2d_pkg::ST_OUT: begin
        // Hold until the output register is free, then advance the position.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = dw2d_pkg::PIX_OUT_W'(mac_acc);
          out_last_nxt  = last_pos;
          state_nxt     = dw2d_pkg::ST_IDLE;
          if (last_pos) begin
            pos_nxt = '0;
            row_nxt = '0;
            col_nxt = '0;
            ch_nxt  = '0;
          end else begin
            pos_nxt = pos_r + 1'b1;
            if (ch_r == CW'(CHANNELS - 1)) begin
              ch_nxt = '0;
              if (col_r == RW'(IMAGE_SIDE - 1)) begin
                col_nxt = '0;
                row_nxt = row_r + 1'b1;
              end else begin
                col_nxt = col_r + 1'b1;
              end
            end else begin
              ch_nxt = ch_r + 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = dw2d_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dw2d_pkg::ST_IDLE;
      pix_ld_r    <= '0;
      wt_ld_r     <= '0;
      pos_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      ch_r        <= '0;
      p1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pix_ld_r    <= pix_ld_nxt;
      wt_ld_r     <= wt_ld_nxt;
      pos_r       <= pos_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      ch_r        <= ch_nxt;
      p1_r        <= (state_r == dw2d_pkg::ST_ISSUE);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kr_r       <= kr_nxt;
    kc_r       <= kc_nxt;
    ir_r       <= ir_nxt;
    ic_r       <= ic_nxt;
    pi_r       <= pi_nxt;
    wi_r       <= wi_nxt;
    inr1_r     <= in_range;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign mac_ctl.tap      = p1_r;
  assign mac_ctl.in_range = inr1_r;
  assign mac_ctl.clear    = fetch_start;

  dw2d_mac #(
    .PIXEL_WIDTH(PIXEL_WIDTH)
  ) u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .pix  (img_rd_r),
    .wt   (wt_rd_r),
    .ctl  (mac_ctl),
    .acc  (mac_acc),
    .busy (mac_busy)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `DW2D_ASSERT_IMPL(a_idle_pipe_empty, state_r == dw2d_pkg::ST_IDLE, !p1_r && !mac_busy)
  `DW2D_ASSERT_IMPL(a_tap_addr_bounds, in_issue && in_range, !pi_r[PIW-1] && (pi_r < PIW'(IMG_COUNT)))
  `DW2D_ASSERT_IMPL(a_weight_addr_bounds, in_issue, wi_r < WIW'(KER_COUNT))
  `DW2D_ASSERT_NEXT(a_fetch_starts, fetch_start, state_r == dw2d_pkg::ST_ISSUE)

endmodule
